// ===== src/max_spanning_tree_kruskal_core_defines.svh =====
// Assertion macros for the spanning tree core checker.
`ifndef MAX_SPANNING_TREE_KRUSKAL_CORE_DEFINES_SVH
`define MAX_SPANNING_TREE_KRUSKAL_CORE_DEFINES_SVH

// Same-cycle implication.
`define MSTK_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("mstk check failed");

// Next-cycle implication.
`define MSTK_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("mstk check failed");

`endif

// ===== src/mstk_pkg.sv =====
// ---------------------------------------------------------------------------
// mstk_pkg
// Shared constants and control types of the spanning tree core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mstk_pkg;

  localparam int VERT_W        = 6;
  localparam int MAX_VERTICES  = 64;
  localparam int VCNT_W        = 7;
  localparam int WEIGHT_W      = 16;
  localparam int TOTAL_W       = 22;
  localparam int SIZE_W        = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_W        = 2 * VERT_W + WEIGHT_W;
  localparam int DEF_MAX_EDGES = 256;
  localparam int VCNT_RESET    = 64;

  localparam logic ITEM_EDGE  = 1'b0;
  localparam logic ITEM_TOTAL = 1'b1;

  typedef struct packed {
    logic load;      // take one input edge
    logic scan_rst;  // index to zero, clear max search
    logic mx_step;   // fold current edge into max search, next index
    logic thr_load;  // current max becomes threshold
    logic e_latch;   // latch current edge, start find on a
    logic idx_inc;   // next index
    logic f_step;    // follow parent link
    logic fa_root;   // root of a found, start find on b
    logic fb_root;   // root of b found
    logic do_union;  // link sets, add weight, load edge result
    logic fin_load;  // load final result
    logic run_clear; // back to empty state
  } mstk_cmd_t;

  typedef struct packed {
    logic last_idx;
    logic cnt_zero;
    logic any_nxt;
    logic w_match;
    logic root;
    logic same_root;
  } mstk_sts_t;

endpackage

// ===== src/mstk_ctrl.sv =====
// ---------------------------------------------------------------------------
// mstk_ctrl
// Sequencer: load, max-weight passes, union-find and result transfers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_edge,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mstk_pkg::mstk_sts_t sts,
  output mstk_pkg::mstk_cmd_t cmd
);

  typedef enum logic [13:0] {
    S_LOAD   = 14'b00000000000001,
    S_START  = 14'b00000000000010,
    S_MX_RD  = 14'b00000000000100,
    S_MX_CMP = 14'b00000000001000,
    S_E_RD   = 14'b00000000010000,
    S_E_CHK  = 14'b00000000100000,
    S_FA_RD  = 14'b00000001000000,
    S_FA_CHK = 14'b00000010000000,
    S_FB_RD  = 14'b00000100000000,
    S_FB_CHK = 14'b00001000000000,
    S_UNION  = 14'b00010000000000,
    S_OUT    = 14'b00100000000000,
    S_FIN    = 14'b01000000000000,
    S_FOUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_OUT) || (state_r == S_FOUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_edge) state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.cnt_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan_rst = 1'b1;
          state_nxt    = S_MX_RD;
        end
      end
      S_MX_RD: state_nxt = S_MX_CMP;
      S_MX_CMP: begin
        if (!sts.last_idx) begin
          cmd.mx_step = 1'b1;
          state_nxt   = S_MX_RD;
        end else if (sts.any_nxt) begin
          cmd.thr_load = 1'b1;
          cmd.scan_rst = 1'b1;
          state_nxt    = S_E_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_E_RD: state_nxt = S_E_CHK;
      S_E_CHK: begin
        if (sts.w_match) begin
          cmd.e_latch = 1'b1;
          state_nxt   = S_FA_RD;
        end else if (sts.last_idx) begin
          cmd.scan_rst = 1'b1;
          state_nxt    = S_MX_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_E_RD;
        end
      end
      S_FA_RD: state_nxt = S_FA_CHK;
      S_FA_CHK: begin
        if (sts.root) begin
          cmd.fa_root = 1'b1;
          state_nxt   = S_FB_RD;
        end else begin
          cmd.f_step = 1'b1;
          state_nxt  = S_FA_RD;
        end
      end
      S_FB_RD: state_nxt = S_FB_CHK;
      S_FB_CHK: begin
        if (!sts.root) begin
          cmd.f_step = 1'b1;
          state_nxt  = S_FB_RD;
        end else if (sts.same_root) begin
          if (sts.last_idx) begin
            cmd.scan_rst = 1'b1;
            state_nxt    = S_MX_RD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_E_RD;
          end
        end else begin
          cmd.fb_root = 1'b1;
          state_nxt   = S_UNION;
        end
      end
      S_UNION: begin
        cmd.do_union = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (sts.last_idx) begin
            cmd.scan_rst = 1'b1;
            state_nxt    = S_MX_RD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_E_RD;
          end
        end
      end
      S_FIN: begin
        cmd.fin_load = 1'b1;
        state_nxt    = S_FOUT;
      end
      S_FOUT: begin
        if (!out_stall) begin
          cmd.run_clear = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule

// ===== src/mstk_dpath.sv =====
// ---------------------------------------------------------------------------
// mstk_dpath
// Edge store, max search, union-find memories and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstk_dpath #(
  parameter int MAX_EDGES = mstk_pkg::DEF_MAX_EDGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mstk_pkg::mstk_cmd_t           cmd,
  output mstk_pkg::mstk_sts_t           sts,
  input  logic                          cfg_valid,
  input  logic [mstk_pkg::VCNT_W-1:0]   cfg_vertex_count,
  input  logic [mstk_pkg::VERT_W-1:0]   in_vertex_a,
  input  logic [mstk_pkg::VERT_W-1:0]   in_vertex_b,
  input  logic [mstk_pkg::WEIGHT_W-1:0] in_weight,
  output logic                          out_item_kind,
  output logic [mstk_pkg::VERT_W-1:0]   out_edge_a,
  output logic [mstk_pkg::VERT_W-1:0]   out_edge_b,
  output logic [mstk_pkg::WEIGHT_W-1:0] out_edge_weight,
  output logic [mstk_pkg::TOTAL_W-1:0]  out_total_weight,
  output logic                          out_dropped_flag,
  output logic                          out_last_result
);

  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int VW     = mstk_pkg::VERT_W;
  localparam int WW     = mstk_pkg::WEIGHT_W;
  localparam int SW     = mstk_pkg::SIZE_W;
  localparam int TW     = mstk_pkg::TOTAL_W;
  localparam int NV     = mstk_pkg::MAX_VERTICES;

  logic [mstk_pkg::EDGE_W-1:0] emem [MAX_EDGES];
  logic [VW-1:0]               pmem [NV];
  logic [SW-1:0]               smem [NV];

  logic [mstk_pkg::VCNT_W-1:0] vcnt_r;
  logic [ECNT_W-1:0]           cnt_r;
  logic [EIDX_W-1:0]           idx_r;
  logic                        drop_r;
  logic [TW-1:0]               total_r;
  logic [mstk_pkg::EDGE_W-1:0] eq_r;
  logic [WW-1:0]               best_r, thr_r;
  logic                        found_r, thr_vld_r;
  logic [NV-1:0]               pvld_r, svld_r;
  logic [VW-1:0]               pq_r, fx_r, ra_r, rb_r, eb_r, ea_r;
  logic [SW-1:0]               sq_r, sa_r, sb_r;
  logic                        pv_q_r, sv_q_r;
  logic [WW-1:0]               ew_r;

  logic [mstk_pkg::VCNT_W-1:0] vc_eff;
  logic                        drop_now;
  logic [VW-1:0]               q_a, q_b, p_eff, big, sub_root;
  logic [WW-1:0]               q_w, best_nxt;
  logic                        cand;
  logic [SW-1:0]               s_eff;

  assign vc_eff   = (vcnt_r > mstk_pkg::VCNT_W'(NV)) ? mstk_pkg::VCNT_W'(NV) : vcnt_r;
  assign drop_now = ({1'b0, in_vertex_a} >= vc_eff) || ({1'b0, in_vertex_b} >= vc_eff)
                    || (cnt_r == ECNT_W'(MAX_EDGES));

  assign {q_a, q_b, q_w} = eq_r;
  assign cand     = !thr_vld_r || (q_w < thr_r);
  assign best_nxt = (cand && (!found_r || (q_w > best_r))) ? q_w : best_r;
  assign p_eff    = pv_q_r ? pq_r : fx_r;
  assign s_eff    = sv_q_r ? sq_r : SW'(1);
  assign big      = (sa_r < sb_r) ? rb_r : ra_r;
  assign sub_root = (sa_r < sb_r) ? ra_r : rb_r;

  assign sts.last_idx  = ((ECNT_W'(idx_r) + ECNT_W'(1)) == cnt_r);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.any_nxt   = found_r | cand;
  assign sts.w_match   = (q_w == thr_r);
  assign sts.root      = (p_eff == fx_r);
  assign sts.same_root = (ra_r == fx_r);

  // memories: registered reads
  always_ff @(posedge clk) begin
    if (cmd.load && !drop_now) begin
      emem[cnt_r[EIDX_W-1:0]] <= {in_vertex_a, in_vertex_b, in_weight};
    end
    eq_r <= emem[idx_r];
    if (cmd.do_union) begin
      pmem[sub_root] <= big;
      smem[big]      <= SW'(sa_r + sb_r);
    end
    pq_r <= pmem[fx_r];
    sq_r <= smem[fx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r    <= mstk_pkg::VCNT_W'(mstk_pkg::VCNT_RESET);
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      total_r   <= '0;
      idx_r     <= '0;
      found_r   <= 1'b0;
      thr_vld_r <= 1'b0;
      pvld_r    <= '0;
      svld_r    <= '0;
      pv_q_r    <= 1'b0;
      sv_q_r    <= 1'b0;
    end else begin
      pv_q_r <= pvld_r[fx_r];
      sv_q_r <= svld_r[fx_r];
      if (cfg_valid) vcnt_r <= cfg_vertex_count;
      if (cmd.load) begin
        if (drop_now) drop_r <= 1'b1;
        else          cnt_r  <= cnt_r + ECNT_W'(1);
      end
      if (cmd.mx_step) begin
        best_r  <= best_nxt;
        found_r <= sts.any_nxt;
        idx_r   <= idx_r + EIDX_W'(1);
      end
      if (cmd.idx_inc) idx_r <= idx_r + EIDX_W'(1);
      if (cmd.thr_load) begin
        thr_r     <= best_nxt;
        thr_vld_r <= 1'b1;
      end
      if (cmd.scan_rst) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end
      if (cmd.do_union) begin
        pvld_r[sub_root] <= 1'b1;
        svld_r[big]      <= 1'b1;
        total_r          <= TW'(total_r + TW'(ew_r));
      end
      if (cmd.run_clear) begin
        cnt_r     <= '0;
        drop_r    <= 1'b0;
        total_r   <= '0;
        thr_vld_r <= 1'b0;
        pvld_r    <= '0;
        svld_r    <= '0;
      end
    end
  end

  // find walker and result registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.e_latch) begin
      ea_r <= q_a;
      eb_r <= q_b;
      ew_r <= q_w;
      fx_r <= q_a;
    end
    if (cmd.f_step) fx_r <= p_eff;
    if (cmd.fa_root) begin
      ra_r <= fx_r;
      sa_r <= s_eff;
      fx_r <= eb_r;
    end
    if (cmd.fb_root) begin
      rb_r <= fx_r;
      sb_r <= s_eff;
    end
    if (cmd.do_union) begin
      out_item_kind    <= mstk_pkg::ITEM_EDGE;
      out_edge_a       <= ea_r;
      out_edge_b       <= eb_r;
      out_edge_weight  <= ew_r;
      out_total_weight <= '0;
      out_dropped_flag <= drop_r;
      out_last_result  <= 1'b0;
    end
    if (cmd.fin_load) begin
      out_item_kind    <= mstk_pkg::ITEM_TOTAL;
      out_edge_a       <= '0;
      out_edge_b       <= '0;
      out_edge_weight  <= '0;
      out_total_weight <= total_r;
      out_dropped_flag <= drop_r;
      out_last_result  <= 1'b1;
    end
  end

endmodule

// ===== src/max_spanning_tree_kruskal_core.sv =====
// Loading: edges load at one per cycle in the load state; after the last edge the run
//   scans the store for each distinct weight, walks parent links for each find step and
//   emits the tree edges; the edge store has one read port.
// Throughput: one edge set per run; the next load starts after the final transfer.
// Reset: synchronous active-low rst_n empties the store and sets vertex_count to 64.
// ---------------------------------------------------------------------------
// max_spanning_tree_kruskal_core
// Kruskal maximum spanning tree with union-find, controller plus datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Edges are stored as they arrive; out-of-range endpoints or a full store
// drop the edge and raise the drop flag for the run.
// The run repeats two scans of the store: the first finds the largest weight
// below the previous threshold, the second visits edges of exactly that
// weight in load order, so ties keep load order.
// Each visited edge walks parent links for both endpoints (union by size keeps
// trees shallow); differing roots are linked and the edge is transferred.
// Parent and size memories carry per-entry valid bits, cleared at once at
// the end of a run, so an unwritten vertex reads as its own root of size one.

module max_spanning_tree_kruskal_core #(
  parameter int MAX_EDGES = mstk_pkg::DEF_MAX_EDGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mstk_pkg::VCNT_W-1:0]   cfg_vertex_count,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mstk_pkg::VERT_W-1:0]   in_vertex_a,
  input  logic [mstk_pkg::VERT_W-1:0]   in_vertex_b,
  input  logic [mstk_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                          in_last_edge,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_item_kind,
  output logic [mstk_pkg::VERT_W-1:0]   out_edge_a,
  output logic [mstk_pkg::VERT_W-1:0]   out_edge_b,
  output logic [mstk_pkg::WEIGHT_W-1:0] out_edge_weight,
  output logic [mstk_pkg::TOTAL_W-1:0]  out_total_weight,
  output logic                          out_dropped_flag,
  output logic                          out_last_result
);

  mstk_pkg::mstk_cmd_t cmd;
  mstk_pkg::mstk_sts_t sts;

  // the user must write the register only while idle; the block does not enforce it, so always accept
  assign cfg_ready = 1'b1;

  mstk_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_edge (in_last_edge),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mstk_dpath #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_vertex_count (cfg_vertex_count),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_weight        (in_weight),
    .out_item_kind    (out_item_kind),
    .out_edge_a       (out_edge_a),
    .out_edge_b       (out_edge_b),
    .out_edge_weight  (out_edge_weight),
    .out_total_weight (out_total_weight),
    .out_dropped_flag (out_dropped_flag),
    .out_last_result  (out_last_result)
  );

endmodule

// ===== src/mstk_checker.sv =====
// ---------------------------------------------------------------------------
// mstk_checker
// Port-level checks of the spanning tree core, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_spanning_tree_kruskal_core_defines.svh"

module mstk_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_item_kind,
  input logic                         out_last_result,
  input logic [mstk_pkg::TOTAL_W-1:0] out_total_weight
);

  logic out_xfer;
  logic out_edge_item;

  assign out_xfer      = out_valid && !out_stall;
  assign out_edge_item = out_valid && (out_item_kind == mstk_pkg::ITEM_EDGE);

  `MSTK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `MSTK_ASSERT_NOW(a_no_overlap, clk, rst_n, !in_stall, !out_valid)
  `MSTK_ASSERT_NEXT(a_ready_after_final, clk, rst_n, out_xfer && out_last_result, !in_stall)
  `MSTK_ASSERT_NOW(a_kind_last, clk, rst_n, out_valid, out_item_kind == out_last_result)
  `MSTK_ASSERT_NOW(a_edge_zero_total, clk, rst_n, out_edge_item, out_total_weight == '0)

endmodule

bind max_spanning_tree_kruskal_core mstk_checker u_mstk_checker (.*);

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the Kruskal maximum spanning tree core: edge sets
// are loaded over the input channel and every tree edge and final total is
// compared against a behavioural spanning tree predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int   VERT_W        = mstk_pkg::VERT_W;
  localparam int   VCNT_W        = mstk_pkg::VCNT_W;
  localparam int   WEIGHT_W      = mstk_pkg::WEIGHT_W;
  localparam int   TOTAL_W       = mstk_pkg::TOTAL_W;
  localparam int   MAX_VERTICES  = mstk_pkg::MAX_VERTICES;
  localparam int   VCNT_RESET    = mstk_pkg::VCNT_RESET;
  localparam logic ITEM_EDGE     = mstk_pkg::ITEM_EDGE;
  localparam logic ITEM_TOTAL    = mstk_pkg::ITEM_TOTAL;

  localparam int STORE_DEPTH   = mstk_pkg::DEF_MAX_EDGES;
  localparam int RANDOM_ITEMS  = 193;
  localparam int WATCHDOG_MAX  = 200000;
  localparam int LONG_HOLD     = 500;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [VERT_W-1:0]   a;
    logic [VERT_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
    logic                last;
  } graph_edge_t;

  typedef struct {
    logic                kind;
    logic [VERT_W-1:0]   a;
    logic [VERT_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
    logic [TOTAL_W-1:0]  total;
    logic                dropped;
    logic                last;
  } tree_item_t;

  // directed row: optional vertex count write before it, optional typed total
  typedef struct {
    int                 vcfg;   // -1 keeps the current count
    graph_edge_t        e;
    bit                 typed;
    logic [TOTAL_W-1:0] total;
    logic               dropped;
  } directed_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [VCNT_W-1:0]   cfg_vertex_count;
  logic                in_valid;
  logic                in_stall;
  logic [VERT_W-1:0]   in_vertex_a;
  logic [VERT_W-1:0]   in_vertex_b;
  logic [WEIGHT_W-1:0] in_weight;
  logic                in_last_edge;
  logic                out_valid;
  logic                out_stall;
  logic                out_item_kind;
  logic [VERT_W-1:0]   out_edge_a;
  logic [VERT_W-1:0]   out_edge_b;
  logic [WEIGHT_W-1:0] out_edge_weight;
  logic [TOTAL_W-1:0]  out_total_weight;
  logic                out_dropped_flag;
  logic                out_last_result;

  max_spanning_tree_kruskal_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_vertex_count (cfg_vertex_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_weight        (in_weight),
    .in_last_edge     (in_last_edge),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item_kind    (out_item_kind),
    .out_edge_a       (out_edge_a),
    .out_edge_b       (out_edge_b),
    .out_edge_weight  (out_edge_weight),
    .out_total_weight (out_total_weight),
    .out_dropped_flag (out_dropped_flag),
    .out_last_result  (out_last_result)
  );

  // Predictor state: its own copy of the register and the loaded set
  logic [VCNT_W-1:0] vertex_limit;
  graph_edge_t       loaded_edges[$];
  logic              set_dropped;
  tree_item_t        tree_queue[$];   // results still owed by the core
  int                error_count;
  int                transfers_out;
  int                idle_cycles;
  int                burst_left;

  // union-find scratch of the predictor
  int uf_parent[MAX_VERTICES];
  int uf_size[MAX_VERTICES];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Spanning tree predictor
  // -------------------------------------------------------------------------
  function automatic int uf_root(int x);
    int r;
    int nxt;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    // path compression: hang every visited node straight off the root
    while (uf_parent[x] != r) begin
      nxt = uf_parent[x];
      uf_parent[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  function automatic void build_tree();
    int          order[$];
    int          j;
    int          ra;
    int          rb;
    int          t;
    logic [TOTAL_W-1:0] sum;
    tree_item_t  it;
    graph_edge_t e;
    // stable descending sort: insert behind every edge of equal weight
    for (int i = 0; i < loaded_edges.size(); i++) begin
      j = order.size();
      while (j > 0 && loaded_edges[order[j-1]].w < loaded_edges[i].w) j--;
      order.insert(j, i);
    end
    for (int v = 0; v < MAX_VERTICES; v++) begin
      uf_parent[v] = v;
      uf_size[v]   = 1;
    end
    sum = '0;
    foreach (order[k]) begin
      e  = loaded_edges[order[k]];
      ra = uf_root(e.a);
      rb = uf_root(e.b);
      if (ra != rb) begin
        // union by size, larger set keeps its root
        if (uf_size[ra] < uf_size[rb]) begin
          t = ra; ra = rb; rb = t;
        end
        uf_size[ra] += uf_size[rb];
        uf_parent[rb] = ra;
        sum = sum + e.w;
        it = '{ITEM_EDGE, e.a, e.b, e.w, '0, set_dropped, 1'b0};
        tree_queue = {tree_queue, it};
      end
    end
    it = '{ITEM_TOTAL, '0, '0, '0, sum, set_dropped, 1'b1};
    tree_queue = {tree_queue, it};
    loaded_edges.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic void load_edge(graph_edge_t e);
    int lim;
    lim = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
    if (e.a >= lim || e.b >= lim || loaded_edges.size() >= STORE_DEPTH)
      set_dropped = 1'b1;
    else
      loaded_edges = {loaded_edges, e};
    if (e.last) build_tree();
  endfunction

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------
  task automatic send_edge(graph_edge_t e);
    in_valid     <= 1'b1;
    in_vertex_a  <= e.a;
    in_vertex_b  <= e.b;
    in_weight    <= e.w;
    in_last_edge <= e.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    load_edge(e);
  endtask

  // bursts of random length with random gaps between them
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register writes only once every owed result has been transferred
  task automatic write_vertex_count(int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tree_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= v[VCNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    vertex_limit = v[VCNT_W-1:0];
  endtask

  function automatic graph_edge_t random_edge(int lim, bit ties, bit last);
    graph_edge_t e;
    int span;
    span = (lim > MAX_VERTICES) ? MAX_VERTICES : lim;
    // mostly in range; the odd edge lands anywhere to hit the range drop
    if (span == 0 || $urandom_range(0, 9) == 0) begin
      e.a = VERT_W'($urandom_range(0, MAX_VERTICES - 1));
      e.b = VERT_W'($urandom_range(0, MAX_VERTICES - 1));
    end else begin
      e.a = VERT_W'($urandom_range(0, span - 1));
      e.b = VERT_W'($urandom_range(0, span - 1));
    end
    e.w    = ties ? 16'($urandom_range(0, 3) * 16'h5555) : 16'($urandom);
    e.last = last;
    return e;
  endfunction

  // -------------------------------------------------------------------------
  // Receiver: checks every transfer, stalls on a shifting pattern
  // -------------------------------------------------------------------------
  int  stall_mode;
  int  mode_left;
  int  hold_left;
  bit  hold_done;
  tree_item_t got;
  tree_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      transfers_out++;
      got = '{out_item_kind, out_edge_a, out_edge_b, out_edge_weight,
              out_total_weight, out_dropped_flag, out_last_result};
      if (tree_queue.size() == 0) begin
        $display("%0t: unexpected transfer kind=%0d a=%0d b=%0d w=%0d total=%0d",
                 $time, got.kind, got.a, got.b, got.w, got.total);
        error_count++;
      end else begin
        want = tree_queue.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: item_kind exp %0d got %0d", $time, want.kind, got.kind);
          error_count++;
        end
        if (got.a !== want.a) begin
          $display("%0t: edge_a exp %0d got %0d", $time, want.a, got.a);
          error_count++;
        end
        if (got.b !== want.b) begin
          $display("%0t: edge_b exp %0d got %0d", $time, want.b, got.b);
          error_count++;
        end
        if (got.w !== want.w) begin
          $display("%0t: edge_weight exp %0d got %0d", $time, want.w, got.w);
          error_count++;
        end
        if (got.total !== want.total) begin
          $display("%0t: total_weight exp %0d got %0d", $time, want.total, got.total);
          error_count++;
        end
        if (got.dropped !== want.dropped) begin
          $display("%0t: dropped_flag exp %0d got %0d", $time, want.dropped,
                   got.dropped);
          error_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_result exp %0d got %0d", $time, want.last, got.last);
          error_count++;
        end
      end
    end

    // one long hold-off mid-run, started while the sender is offering an
    // edge, so the core backs up onto its input
    if (!hold_done && transfers_out >= 30 && out_valid && in_valid && in_stall) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;                            // free running
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ~out_stall;                      // alternating stall and release
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // watchdog: cycles in which no transfer happens on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               tree_queue.size());
      $display("FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Directed table
  // -------------------------------------------------------------------------
  directed_row_t directed[] = '{
    // reset count of 64: both extreme vertices, full-scale weight
    '{-1,  '{6'd0,  6'd63, 16'hFFFF, 1'b1}, 1'b1, 22'd65535, 1'b0},
    // self loop alone gives only the total
    '{-1,  '{6'd5,  6'd5,  16'd100,  1'b1}, 1'b1, 22'd0,     1'b0},
    // ties and reverse duplicates: heaviest first, a pair already joined is skipped
    '{-1,  '{6'd63, 6'd0,  16'd0,    1'b0}, 1'b0, 22'd0,     1'b0},
    '{-1,  '{6'd1,  6'd2,  16'd7,    1'b0}, 1'b0, 22'd0,     1'b0},
    '{-1,  '{6'd2,  6'd1,  16'd7,    1'b0}, 1'b0, 22'd0,     1'b0},
    '{-1,  '{6'd1,  6'd2,  16'd9,    1'b1}, 1'b1, 22'd9,     1'b0},
    // single vertex: second endpoint out of range
    '{1,   '{6'd0,  6'd0,  16'd5,    1'b0}, 1'b0, 22'd0,     1'b0},
    '{-1,  '{6'd0,  6'd1,  16'd5,    1'b1}, 1'b1, 22'd0,     1'b1},
    // zero vertices: everything dropped
    '{0,   '{6'd0,  6'd0,  16'd1,    1'b1}, 1'b1, 22'd0,     1'b1},
    // count above the maximum behaves as 64; triangle of equal weights
    '{127, '{6'd63, 6'd62, 16'd40000, 1'b0}, 1'b0, 22'd0,    1'b0},
    '{-1,  '{6'd62, 6'd61, 16'd40000, 1'b0}, 1'b0, 22'd0,    1'b0},
    '{-1,  '{6'd61, 6'd63, 16'd40000, 1'b1}, 1'b1, 22'd80000, 1'b0},
    '{65,  '{6'd42, 6'd21, 16'hAAAA, 1'b0}, 1'b0, 22'd0,     1'b0},
    '{-1,  '{6'd21, 6'd42, 16'h5555, 1'b1}, 1'b1, 22'd43690, 1'b0},
    // eight vertices: vertex 8 is just out of range
    '{8,   '{6'd8,  6'd0,  16'd3,    1'b0}, 1'b0, 22'd0,     1'b0},
    '{-1,  '{6'd7,  6'd0,  16'd3,    1'b0}, 1'b0, 22'd0,     1'b0},
    '{-1,  '{6'd0,  6'd7,  16'd2,    1'b1}, 1'b1, 22'd3,     1'b1}
  };

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int          sent;
    int          set_len;
    int          set_no;
    int          lim;
    bit          ties;
    graph_edge_t e;

    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_vertex_count <= '0;
    in_valid         <= 1'b0;
    in_vertex_a      <= '0;
    in_vertex_b      <= '0;
    in_weight        <= '0;
    in_last_edge     <= 1'b0;
    out_stall        <= 1'b0;
    vertex_limit  = VCNT_W'(VCNT_RESET);
    set_dropped   = 1'b0;
    error_count   = 0;
    transfers_out = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    stall_mode    = 0;
    mode_left     = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r]) begin
      if (directed[r].vcfg >= 0) write_vertex_count(directed[r].vcfg);
      send_edge(directed[r].e);
      // typed totals and drop flags replace those of the predicted final item
      if (directed[r].typed) begin
        tree_queue[$].total   = directed[r].total;
        tree_queue[$].dropped = directed[r].dropped;
      end
      sender_gap();
    end

    // random sets, a fresh vertex count every few sets
    sent   = 0;
    set_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (set_no % 4 == 0) begin
        case ($urandom_range(0, 5))
          0:       lim = 127;
          1:       lim = 2;
          2:       lim = $urandom_range(0, 127);
          default: lim = $urandom_range(2, MAX_VERTICES);
        endcase
        write_vertex_count(lim);
      end
      set_len = $urandom_range(1, 14);
      ties    = $urandom_range(0, 1);
      for (int i = 0; i < set_len; i++) begin
        e = random_edge(vertex_limit, ties, i == set_len - 1);
        send_edge(e);
        sender_gap();
      end
      sent += set_len;
      set_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (tree_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== max_spanning_tree_kruskal_core.f =====
+incdir+src
src/mstk_pkg.sv
src/mstk_ctrl.sv
src/mstk_dpath.sv
src/max_spanning_tree_kruskal_core.sv
src/mstk_checker.sv
verif/testbench.sv
